/* rtl/core/abg_pkg.sv */
`default_nettype none

package abg_pkg;

	localparam int MAX_SIZE_ENTRIES_DEF  = 4;
	localparam int MAX_RATIO_ENTRIES_DEF = 8;

	// ratio one in Q4.12, also its root
	localparam logic [15:0] RATIO_ONE = 16'd4096;

	localparam int QUEUE_DEPTH = 2;

	// divider: 42-bit dividend, 16-bit divisor; root unit: 48-bit radicand
	localparam int DIV_NW  = 42;
	localparam int DIV_DW  = 16;
	localparam int SQRT_NW = 48;

	typedef enum logic [1:0] {
		OP_CLEAR,
		OP_LOAD_SIZE,
		OP_LOAD_RATIO,
		OP_GENERATE
	} op_t;

	typedef enum logic [2:0] {
		CFG_IMAGE_WIDTH,
		CFG_IMAGE_HEIGHT,
		CFG_STEP_X,
		CFG_STEP_Y,
		CFG_CENTER_OFFSET,
		CFG_CLIP_ENABLE,
		CFG_FLIP_ENABLE,
		CFG_MAX_BOX_ENABLE
	} cfg_idx_t;

	typedef struct packed {
		logic [12:0] image_width;
		logic [12:0] image_height;
		logic [15:0] step_x;
		logic [15:0] step_y;
		logic [7:0]  center_offset;
		logic        clip_enable;
		logic        flip_enable;
		logic        max_box_enable;
	} cfg_t;

	typedef struct packed {
		op_t         op;
		logic [15:0] min_size;
		logic [15:0] max_size;
		logic [15:0] aspect_ratio;
		logic [9:0]  cell_row;
		logic [9:0]  cell_col;
	} item_t;

	typedef enum logic [1:0] {
		BOX_MIN,
		BOX_MEAN,
		BOX_RATIO
	} box_kind_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_RSQ_GO,
		ST_RSQ_WAIT,
		ST_RDIV_GO,
		ST_RDIV_WAIT,
		ST_RSQ2_GO,
		ST_RSQ2_WAIT,
		ST_MUL_X,
		ST_MUL_Y,
		ST_BOX,
		ST_MUL_M,
		ST_SQM_GO,
		ST_SQM_WAIT,
		ST_RSCAN,
		ST_MUL_W,
		ST_DIVH_GO,
		ST_DIVH_WAIT,
		ST_EDGE,
		ST_EDGE_GO,
		ST_EDGE_WAIT,
		ST_OUT
	} state_t;

endpackage

`default_nettype wire

/* rtl/core/abg_front.sv */
`default_nettype none

module abg_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic [1:0]     op,
	input  wire logic [15:0]    min_size,
	input  wire logic [15:0]    max_size,
	input  wire logic [15:0]    aspect_ratio,
	input  wire logic [9:0]     cell_row,
	input  wire logic [9:0]     cell_col,
	output logic                item_valid,
	output abg_pkg::item_t      item,
	input  wire logic           item_pop
);

	localparam int QAW = (abg_pkg::QUEUE_DEPTH > 1) ? $clog2(abg_pkg::QUEUE_DEPTH) : 1;
	localparam int QCW = $clog2(abg_pkg::QUEUE_DEPTH + 1);

	abg_pkg::item_t   q_mem [abg_pkg::QUEUE_DEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QCW-1:0]   cnt_q;
	abg_pkg::item_t   in_item;
	logic             push;
	logic             pop;

	always_comb begin
		in_item.op           = abg_pkg::op_t'(op);
		in_item.min_size     = min_size;
		in_item.max_size     = max_size;
		in_item.aspect_ratio = aspect_ratio;
		in_item.cell_row     = cell_row;
		in_item.cell_col     = cell_col;
	end

	assign in_ready   = (cnt_q != QCW'(abg_pkg::QUEUE_DEPTH));
	assign item_valid = (cnt_q != '0);
	assign item       = q_mem[rd_ptr_q];
	assign push       = in_valid && in_ready;
	assign pop        = item_pop && item_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(abg_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(abg_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QAW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCW'(1);
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/core/abg_div.sv */
`default_nettype none

module abg_div #(
	parameter int NW = abg_pkg::DIV_NW,
	parameter int DW = abg_pkg::DIV_DW
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic               done,
	output logic [NW-1:0]      quo
);

	localparam int CW = $clog2(NW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [NW-1:0] quo_q;
	logic [DW:0]   trial;
	logic          fits;

	// restoring division, one quotient bit a cycle
	assign trial = {rem_q, quo_q[NW-1]};
	assign fits  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
				rem_q  <= '0;
				den_q  <= den;
				quo_q  <= num;
			end else if (busy_q) begin
				if (fits) begin
					rem_q <= DW'(trial - {1'b0, den_q});
					quo_q <= {quo_q[NW-2:0], 1'b1};
				end else begin
					rem_q <= trial[DW-1:0];
					quo_q <= {quo_q[NW-2:0], 1'b0};
				end
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

/* rtl/core/abg_sqrt.sv */
`default_nettype none

module abg_sqrt #(
	parameter int NW = abg_pkg::SQRT_NW
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [NW-1:0]   rad,
	output logic                 done,
	output logic [NW/2-1:0]      res
);

	localparam int RW = NW / 2;
	localparam int CW = $clog2(RW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] rad_q;
	logic [RW:0]   rem_q;
	logic [RW-1:0] res_q;
	logic [RW+2:0] r2;
	logic [RW+2:0] trial;

	// two radicand bits a cycle, one root bit
	assign r2    = {rem_q, rad_q[NW-1:NW-2]};
	assign trial = {1'b0, res_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rad_q  <= '0;
			rem_q  <= '0;
			res_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(RW);
				rad_q  <= rad;
				rem_q  <= '0;
				res_q  <= '0;
			end else if (busy_q) begin
				rad_q <= {rad_q[NW-3:0], 2'b00};
				if (r2 >= trial) begin
					rem_q <= (RW+1)'(r2 - trial);
					res_q <= {res_q[RW-2:0], 1'b1};
				end else begin
					rem_q <= r2[RW:0];
					res_q <= {res_q[RW-2:0], 1'b0};
				end
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

`default_nettype wire

/* rtl/core/abg_back.sv */
`default_nettype none

module abg_back #(
	parameter int MAX_SIZE_ENTRIES  = abg_pkg::MAX_SIZE_ENTRIES_DEF,
	parameter int MAX_RATIO_ENTRIES = abg_pkg::MAX_RATIO_ENTRIES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire abg_pkg::cfg_t      cfg,
	input  wire logic               item_valid,
	input  wire abg_pkg::item_t     item,
	output logic                    item_pop,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [19:0]      x_min,
	output logic signed [19:0]      y_min,
	output logic signed [19:0]      x_max,
	output logic signed [19:0]      y_max,
	output logic                    last_box
);

	localparam int SIW = (MAX_SIZE_ENTRIES > 1) ? $clog2(MAX_SIZE_ENTRIES) : 1;
	localparam int SCW = $clog2(MAX_SIZE_ENTRIES + 1);
	localparam int RIW = (MAX_RATIO_ENTRIES > 1) ? $clog2(MAX_RATIO_ENTRIES) : 1;
	localparam int RCW = $clog2(MAX_RATIO_ENTRIES + 1);
	localparam int NW  = abg_pkg::DIV_NW;
	localparam int DW  = abg_pkg::DIV_DW;
	localparam int QW  = abg_pkg::SQRT_NW;
	localparam int RW  = abg_pkg::SQRT_NW / 2;

	abg_pkg::state_t    state_q;
	abg_pkg::state_t    state_d;
	abg_pkg::box_kind_t kind_q;
	abg_pkg::item_t     cur_q;

	logic [15:0] min_tab   [MAX_SIZE_ENTRIES];
	logic [15:0] max_tab   [MAX_SIZE_ENTRIES];
	logic [15:0] ratio_mem [MAX_RATIO_ENTRIES];
	logic [15:0] root_mem  [MAX_RATIO_ENTRIES];
	logic [15:0] ratio_v   [MAX_RATIO_ENTRIES];
	logic [15:0] root_v    [MAX_RATIO_ENTRIES];

	logic [SCW-1:0] size_cnt_q;
	logic [RCW-1:0] ratio_cnt_q;
	logic [SCW-1:0] k_q;
	logic [RCW-1:0] p_q;
	logic [1:0]     eidx_q;
	logic [15:0]    arg_q;
	logic [33:0]    cx_q;
	logic [33:0]    cy_q;
	logic [33:0]    prod_q;
	logic [30:0]    sw_q;
	logic [30:0]    sh_q;
	logic signed [41:0] n_q;
	logic [13:0]    d_q;
	logic           neg_q;
	logic signed [19:0] box_q [4];

	logic [15:0] cur_s;
	logic [15:0] cur_mx;
	logic [15:0] cur_root;
	logic [MAX_RATIO_ENTRIES-1:0] nonone;
	logic        later;
	logic        last_size;
	logic        dup;
	logic        ratio_ok;
	logic        size_room;
	logic [RCW:0] need;

	logic [17:0] mul_a;
	logic [15:0] mul_b;
	logic [33:0] mul_p;
	logic [33:0] w_round;

	logic [33:0] c_sel;
	logic [30:0] s_sel;
	logic [12:0] img_sel;
	logic [12:0] img1;
	logic signed [36:0] c2;
	logic signed [36:0] ss;
	logic signed [36:0] e;
	logic signed [41:0] e16;
	logic signed [41:0] n_d;

	logic          div_start;
	logic [NW-1:0] div_num;
	logic [DW-1:0] div_den;
	logic          div_done;
	logic [NW-1:0] div_quo;
	logic          sq_start;
	logic [QW-1:0] sq_rad;
	logic          sq_done;
	logic [RW-1:0] sq_res;

	function automatic logic signed [19:0] sat_edge(input logic neg, input logic [41:0] quo,
		input logic clip);
		logic signed [42:0] qs;
		logic signed [19:0] r;
		qs = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
		if (clip) begin
			if (qs < 43'sd0) begin
				r = 20'sd0;
			end else if (qs > 43'sd65536) begin
				r = 20'sd65536;
			end else begin
				r = qs[19:0];
			end
		end else begin
			if (qs > 43'sd524287) begin
				r = 20'sd524287;
			end else if (qs < -43'sd524288) begin
				r = -20'sd524288;
			end else begin
				r = qs[19:0];
			end
		end
		return r;
	endfunction

	// entry zero always holds ratio one
	always_comb begin
		for (int i = 0; i < MAX_RATIO_ENTRIES; i++) begin
			ratio_v[i] = (i == 0) ? abg_pkg::RATIO_ONE : ratio_mem[i];
			root_v[i]  = (i == 0) ? abg_pkg::RATIO_ONE : root_mem[i];
		end
	end

	assign cur_s    = min_tab[k_q[SIW-1:0]];
	assign cur_mx   = max_tab[k_q[SIW-1:0]];
	assign cur_root = root_v[p_q[RIW-1:0]];

	always_comb begin
		later = 1'b0;
		dup   = 1'b0;
		for (int i = 0; i < MAX_RATIO_ENTRIES; i++) begin
			nonone[i] = (RCW'(i) < ratio_cnt_q) && (ratio_v[i] != abg_pkg::RATIO_ONE)
				&& (root_v[i] != '0);
			later = later | (nonone[i] && (RCW'(i) > p_q));
			dup   = dup | ((RCW'(i) < ratio_cnt_q) && (ratio_v[i] == item.aspect_ratio));
		end
	end

	assign need      = cfg.flip_enable ? (RCW+1)'(2) : (RCW+1)'(1);
	assign ratio_ok  = (item.aspect_ratio != '0) && !dup
		&& (({1'b0, ratio_cnt_q} + need) <= (RCW+1)'(MAX_RATIO_ENTRIES));
	assign size_room = (size_cnt_q < SCW'(MAX_SIZE_ENTRIES));
	assign last_size = ((k_q + SCW'(1)) == size_cnt_q);

	// shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			abg_pkg::ST_MUL_X: begin
				mul_a = {cur_q.cell_col, 8'h00} + {10'b0, cfg.center_offset};
				mul_b = cfg.step_x;
			end
			abg_pkg::ST_MUL_Y: begin
				mul_a = {cur_q.cell_row, 8'h00} + {10'b0, cfg.center_offset};
				mul_b = cfg.step_y;
			end
			abg_pkg::ST_MUL_M: begin
				mul_a = {2'b00, cur_s};
				mul_b = cur_mx;
			end
			abg_pkg::ST_MUL_W: begin
				mul_a = {2'b00, cur_s};
				mul_b = cur_root;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p   = mul_a * mul_b;
	assign w_round = prod_q + 34'd8;

	// edge numerator: 16 * (2c -/+ s) + img, rounding half up after the divide
	always_comb begin
		c_sel   = eidx_q[0] ? cy_q : cx_q;
		s_sel   = eidx_q[0] ? sh_q : sw_q;
		img_sel = eidx_q[0] ? cfg.image_height : cfg.image_width;
		img1    = (img_sel == '0) ? 13'd1 : img_sel;
		c2      = $signed({2'b00, c_sel, 1'b0});
		ss      = $signed({6'b0, s_sel});
		e       = eidx_q[1] ? (c2 + ss) : (c2 - ss);
		e16     = {e[36], e, 4'b0000};
		n_d     = e16 + $signed({29'b0, img1});
	end

	// divider and root operand selection
	always_comb begin
		div_num = '0;
		div_den = '0;
		sq_rad  = '0;
		case (state_q)
			abg_pkg::ST_EDGE_GO: begin
				// floor of a negative quotient as minus the ceiling of its magnitude
				div_num = n_q[41] ? ({28'b0, d_q} + ~$unsigned(n_q)) : $unsigned(n_q);
				div_den = {2'b00, d_q};
			end
			abg_pkg::ST_RDIV_GO: begin
				div_num = {17'b0, 25'h1000000 + {10'b0, arg_q[15:1]}};
				div_den = arg_q;
			end
			abg_pkg::ST_DIVH_GO: begin
				div_num = {6'b0, cur_s, 20'b0} + {27'b0, cur_root[15:1]};
				div_den = cur_root;
			end
			abg_pkg::ST_RSQ_GO, abg_pkg::ST_RSQ2_GO: begin
				sq_rad = {20'b0, arg_q, 12'b0};
			end
			abg_pkg::ST_SQM_GO: begin
				sq_rad = {prod_q[31:0], 16'b0};
			end
			default: begin
				div_num = '0;
				div_den = '0;
				sq_rad  = '0;
			end
		endcase
	end

	abg_div #(
		.NW(NW),
		.DW(DW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	abg_sqrt #(
		.NW(QW)
	) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.rad    (sq_rad),
		.done   (sq_done),
		.res    (sq_res)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			abg_pkg::ST_IDLE: begin
				if (item_valid) begin
					unique case (item.op)
						abg_pkg::OP_CLEAR, abg_pkg::OP_LOAD_SIZE: state_d = abg_pkg::ST_IDLE;
						abg_pkg::OP_LOAD_RATIO:
							state_d = ratio_ok ? abg_pkg::ST_RSQ_GO : abg_pkg::ST_IDLE;
						abg_pkg::OP_GENERATE:
							state_d = (size_cnt_q != '0) ? abg_pkg::ST_MUL_X : abg_pkg::ST_IDLE;
						default: state_d = abg_pkg::ST_IDLE;
					endcase
				end
			end
			abg_pkg::ST_RSQ_GO:    state_d = abg_pkg::ST_RSQ_WAIT;
			abg_pkg::ST_RSQ_WAIT: begin
				if (sq_done) begin
					state_d = cfg.flip_enable ? abg_pkg::ST_RDIV_GO : abg_pkg::ST_IDLE;
				end
			end
			abg_pkg::ST_RDIV_GO:   state_d = abg_pkg::ST_RDIV_WAIT;
			abg_pkg::ST_RDIV_WAIT: begin
				if (div_done) begin
					state_d = abg_pkg::ST_RSQ2_GO;
				end
			end
			abg_pkg::ST_RSQ2_GO:   state_d = abg_pkg::ST_RSQ2_WAIT;
			abg_pkg::ST_RSQ2_WAIT: begin
				if (sq_done) begin
					state_d = abg_pkg::ST_IDLE;
				end
			end
			abg_pkg::ST_MUL_X:     state_d = abg_pkg::ST_MUL_Y;
			abg_pkg::ST_MUL_Y:     state_d = abg_pkg::ST_BOX;
			abg_pkg::ST_BOX:       state_d = abg_pkg::ST_EDGE;
			abg_pkg::ST_MUL_M:     state_d = abg_pkg::ST_SQM_GO;
			abg_pkg::ST_SQM_GO:    state_d = abg_pkg::ST_SQM_WAIT;
			abg_pkg::ST_SQM_WAIT: begin
				if (sq_done) begin
					state_d = abg_pkg::ST_EDGE;
				end
			end
			abg_pkg::ST_RSCAN: begin
				if (p_q >= ratio_cnt_q) begin
					state_d = last_size ? abg_pkg::ST_IDLE : abg_pkg::ST_BOX;
				end else if (nonone[p_q[RIW-1:0]]) begin
					state_d = abg_pkg::ST_MUL_W;
				end
			end
			abg_pkg::ST_MUL_W:     state_d = abg_pkg::ST_DIVH_GO;
			abg_pkg::ST_DIVH_GO:   state_d = abg_pkg::ST_DIVH_WAIT;
			abg_pkg::ST_DIVH_WAIT: begin
				if (div_done) begin
					state_d = abg_pkg::ST_EDGE;
				end
			end
			abg_pkg::ST_EDGE:      state_d = abg_pkg::ST_EDGE_GO;
			abg_pkg::ST_EDGE_GO:   state_d = abg_pkg::ST_EDGE_WAIT;
			abg_pkg::ST_EDGE_WAIT: begin
				if (div_done) begin
					state_d = (eidx_q == 2'd3) ? abg_pkg::ST_OUT : abg_pkg::ST_EDGE;
				end
			end
			abg_pkg::ST_OUT: begin
				if (out_ready) begin
					if (kind_q == abg_pkg::BOX_MIN && cfg.max_box_enable) begin
						state_d = abg_pkg::ST_MUL_M;
					end else begin
						state_d = abg_pkg::ST_RSCAN;
					end
				end
			end
			default: state_d = abg_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		item_pop  = (state_q == abg_pkg::ST_IDLE) && item_valid;
		out_valid = (state_q == abg_pkg::ST_OUT);
		div_start = (state_q == abg_pkg::ST_EDGE_GO) || (state_q == abg_pkg::ST_RDIV_GO)
			|| (state_q == abg_pkg::ST_DIVH_GO);
		sq_start  = (state_q == abg_pkg::ST_RSQ_GO) || (state_q == abg_pkg::ST_RSQ2_GO)
			|| (state_q == abg_pkg::ST_SQM_GO);
		case (kind_q)
			abg_pkg::BOX_MIN:   last_box = last_size && !cfg.max_box_enable && !(|nonone);
			abg_pkg::BOX_MEAN:  last_box = last_size && !(|nonone);
			abg_pkg::BOX_RATIO: last_box = last_size && !later;
			default:            last_box = 1'b0;
		endcase
	end

	assign x_min = box_q[0];
	assign y_min = box_q[1];
	assign x_max = box_q[2];
	assign y_max = box_q[3];

	// table storage
	always_ff @(posedge clk) begin
		if (state_q == abg_pkg::ST_IDLE && item_valid && item.op == abg_pkg::OP_LOAD_SIZE
			&& size_room) begin
			min_tab[size_cnt_q[SIW-1:0]] <= item.min_size;
			max_tab[size_cnt_q[SIW-1:0]] <= item.max_size;
		end
		if ((state_q == abg_pkg::ST_RSQ_WAIT || state_q == abg_pkg::ST_RSQ2_WAIT) && sq_done) begin
			ratio_mem[ratio_cnt_q[RIW-1:0]] <= arg_q;
			root_mem[ratio_cnt_q[RIW-1:0]]  <= sq_res[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= abg_pkg::ST_IDLE;
			kind_q      <= abg_pkg::BOX_MIN;
			cur_q       <= '0;
			size_cnt_q  <= '0;
			ratio_cnt_q <= RCW'(1);
			k_q         <= '0;
			p_q         <= '0;
			eidx_q      <= '0;
			arg_q       <= '0;
			cx_q        <= '0;
			cy_q        <= '0;
			prod_q      <= '0;
			sw_q        <= '0;
			sh_q        <= '0;
			n_q         <= '0;
			d_q         <= '0;
			neg_q       <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				box_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			case (state_q)
				abg_pkg::ST_IDLE: begin
					if (item_valid) begin
						cur_q <= item;
						arg_q <= item.aspect_ratio;
						k_q   <= '0;
						case (item.op)
							abg_pkg::OP_CLEAR: begin
								size_cnt_q  <= '0;
								ratio_cnt_q <= RCW'(1);
							end
							abg_pkg::OP_LOAD_SIZE: begin
								if (size_room) begin
									size_cnt_q <= size_cnt_q + SCW'(1);
								end
							end
							default: ;
						endcase
					end
				end
				abg_pkg::ST_RSQ_WAIT, abg_pkg::ST_RSQ2_WAIT: begin
					if (sq_done) begin
						ratio_cnt_q <= ratio_cnt_q + RCW'(1);
					end
				end
				abg_pkg::ST_RDIV_WAIT: begin
					if (div_done) begin
						arg_q <= (div_quo > NW'(65535)) ? 16'hFFFF : div_quo[15:0];
					end
				end
				abg_pkg::ST_MUL_X: cx_q <= mul_p;
				abg_pkg::ST_MUL_Y: cy_q <= mul_p;
				abg_pkg::ST_BOX: begin
					sw_q   <= {7'b0, cur_s, 8'b0};
					sh_q   <= {7'b0, cur_s, 8'b0};
					kind_q <= abg_pkg::BOX_MIN;
					eidx_q <= '0;
				end
				abg_pkg::ST_MUL_M, abg_pkg::ST_MUL_W: prod_q <= mul_p;
				abg_pkg::ST_SQM_WAIT: begin
					if (sq_done) begin
						sw_q   <= {7'b0, sq_res};
						sh_q   <= {7'b0, sq_res};
						kind_q <= abg_pkg::BOX_MEAN;
						eidx_q <= '0;
					end
				end
				abg_pkg::ST_RSCAN: begin
					if (p_q >= ratio_cnt_q) begin
						k_q <= k_q + SCW'(1);
					end else if (!nonone[p_q[RIW-1:0]]) begin
						p_q <= p_q + RCW'(1);
					end
				end
				abg_pkg::ST_DIVH_GO: sw_q <= {1'b0, w_round[33:4]};
				abg_pkg::ST_DIVH_WAIT: begin
					if (div_done) begin
						sh_q   <= div_quo[30:0];
						kind_q <= abg_pkg::BOX_RATIO;
						eidx_q <= '0;
					end
				end
				abg_pkg::ST_EDGE: begin
					n_q <= n_d;
					d_q <= {img1, 1'b0};
				end
				abg_pkg::ST_EDGE_GO: neg_q <= n_q[41];
				abg_pkg::ST_EDGE_WAIT: begin
					if (div_done) begin
						box_q[eidx_q] <= sat_edge(neg_q, div_quo, cfg.clip_enable);
						eidx_q        <= eidx_q + 2'd1;
					end
				end
				abg_pkg::ST_OUT: begin
					if (out_ready) begin
						p_q <= (kind_q == abg_pkg::BOX_RATIO) ? p_q + RCW'(1) : '0;
					end
				end
				default: ;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_ratio_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ratio_cnt_q >= RCW'(1)) && (ratio_cnt_q <= RCW'(MAX_RATIO_ENTRIES)))
		else $error("ratio count out of range");

	a_size_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		size_cnt_q <= SCW'(MAX_SIZE_ENTRIES))
		else $error("size count out of range");

	a_busy_after_inner_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last_box) |=> (state_q != abg_pkg::ST_IDLE))
		else $error("cell ended without a last box");

	a_no_pop_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == abg_pkg::ST_OUT) |=> !item_pop)
		else $error("item taken while a box is pending");
`endif

endmodule

`default_nettype wire

/* rtl/core/anchor_box_generator.sv */
`default_nettype none

// SSD prior-box generator. Items enter a two-beat queue and are carried out one at a time by a
// sequencer built around one shared divider, one square-root unit and one 18x16 multiplier.
// Clear and size loads are handled in idle. A ratio load runs a root, or with flip a root, a
// reciprocal divide and a second root. A generate item first forms the cell centre on the
// multiplier, then each box spends four divider runs on its normalized edges, plus a root run
// for the mean box or a divide for a ratio box, and the sequencer steps past each skipped
// ratio entry; the divider is what sets the pace. Boxes leave in load order of sizes, each
// size giving its min box, its mean box when enabled, then one box per stored ratio other than
// one; the final box of a cell carries last_box. There is no clearing pass after reset.
module anchor_box_generator #(
	parameter int MAX_SIZE_ENTRIES  = abg_pkg::MAX_SIZE_ENTRIES_DEF,
	parameter int MAX_RATIO_ENTRIES = abg_pkg::MAX_RATIO_ENTRIES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [15:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         op,
	input  wire logic [15:0]        min_size,
	input  wire logic [15:0]        max_size,
	input  wire logic [15:0]        aspect_ratio,
	input  wire logic [9:0]         cell_row,
	input  wire logic [9:0]         cell_col,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [19:0]      x_min,
	output logic signed [19:0]      y_min,
	output logic signed [19:0]      x_max,
	output logic signed [19:0]      y_max,
	output logic                    last_box
);

	abg_pkg::cfg_t  cfg_q;
	abg_pkg::item_t item;
	logic           item_valid;
	logic           item_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width    <= 13'd300;
			cfg_q.image_height   <= 13'd300;
			cfg_q.step_x         <= 16'd128;
			cfg_q.step_y         <= 16'd128;
			cfg_q.center_offset  <= 8'd128;
			cfg_q.clip_enable    <= 1'b0;
			cfg_q.flip_enable    <= 1'b1;
			cfg_q.max_box_enable <= 1'b0;
		end else if (cfg_we) begin
			unique case (abg_pkg::cfg_idx_t'(cfg_index))
				abg_pkg::CFG_IMAGE_WIDTH:    cfg_q.image_width    <= cfg_data[12:0];
				abg_pkg::CFG_IMAGE_HEIGHT:   cfg_q.image_height   <= cfg_data[12:0];
				abg_pkg::CFG_STEP_X:         cfg_q.step_x         <= cfg_data;
				abg_pkg::CFG_STEP_Y:         cfg_q.step_y         <= cfg_data;
				abg_pkg::CFG_CENTER_OFFSET:  cfg_q.center_offset  <= cfg_data[7:0];
				abg_pkg::CFG_CLIP_ENABLE:    cfg_q.clip_enable    <= cfg_data[0];
				abg_pkg::CFG_FLIP_ENABLE:    cfg_q.flip_enable    <= cfg_data[0];
				abg_pkg::CFG_MAX_BOX_ENABLE: cfg_q.max_box_enable <= cfg_data[0];
				default: ;
			endcase
		end
	end

	abg_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.min_size     (min_size),
		.max_size     (max_size),
		.aspect_ratio (aspect_ratio),
		.cell_row     (cell_row),
		.cell_col     (cell_col),
		.item_valid   (item_valid),
		.item         (item),
		.item_pop     (item_pop)
	);

	abg_back #(
		.MAX_SIZE_ENTRIES  (MAX_SIZE_ENTRIES),
		.MAX_RATIO_ENTRIES (MAX_RATIO_ENTRIES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.x_min      (x_min),
		.y_min      (y_min),
		.x_max      (x_max),
		.y_max      (y_max),
		.last_box   (last_box)
	);

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
	import abg_pkg::*;

	typedef struct {
		logic signed [19:0] x_min, y_min, x_max, y_max;
		logic               last;
	} box_t;

	typedef struct {
		item_t it;
		bit    typed;
		box_t  bx;
	} row_t;

	logic clk, arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [15:0] cfg_data;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [1:0] op;
	logic [15:0] min_size, max_size, aspect_ratio;
	logic [9:0] cell_row, cell_col;
	logic signed [19:0] x_min, y_min, x_max, y_max;
	logic last_box;

	anchor_box_generator dut (.*);

	// prior-box state as the block should hold it
	int unsigned img_w, img_h, pitch_x, pitch_y, ctr_off;
	bit clip_on, flip_on, mean_on;
	int unsigned size_lo [MAX_SIZE_ENTRIES_DEF];
	int unsigned size_hi [MAX_SIZE_ENTRIES_DEF];
	int unsigned size_cnt;
	int unsigned ratio_val [MAX_RATIO_ENTRIES_DEF];
	int unsigned ratio_rt [MAX_RATIO_ENTRIES_DEF];
	int unsigned ratio_cnt;

	box_t pending_boxes[$];
	int errors, items_sent, boxes_seen, cfg_writes;
	int tx_idle_pct, rx_idle_pct, rx_hold;
	row_t dir_rows[$];

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#100ms;
		$display("FAIL");
		$finish;
	end

	function automatic longint unsigned int_root(longint unsigned n);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else
				res >>= 1;
			b >>= 2;
		end
		return res;
	endfunction

	function automatic logic signed [19:0] norm_edge(longint e, int unsigned img);
		longint d, n, q;
		d = (img == 0 ? 1 : img) * 2;
		n = e * 16 + d / 2;
		q = n / d;
		if ((n % d) != 0 && n < 0) q--;
		if (clip_on) begin
			if (q < 0) q = 0;
			if (q > 65536) q = 65536;
		end else begin
			if (q < -524288) q = -524288;
			if (q > 524287) q = 524287;
		end
		return q[19:0];
	endfunction

	function automatic box_t make_box(longint cx, longint cy, longint sw, longint sh);
		box_t b;
		b.x_min = norm_edge(2 * cx - sw, img_w);
		b.y_min = norm_edge(2 * cy - sh, img_h);
		b.x_max = norm_edge(2 * cx + sw, img_w);
		b.y_max = norm_edge(2 * cy + sh, img_h);
		b.last  = 1'b0;
		return b;
	endfunction

	function automatic void reset_tables();
		foreach (ratio_val[i]) begin
			ratio_val[i] = 0;
			ratio_rt[i]  = 0;
		end
		ratio_val[0] = RATIO_ONE;
		ratio_rt[0]  = RATIO_ONE;
		ratio_cnt = 1;
		size_cnt = 0;
	endfunction

	function automatic void add_ratio(int unsigned r);
		int unsigned need;
		longint unsigned rec;
		need = flip_on ? 2 : 1;
		if (r == 0) return;
		for (int i = 0; i < ratio_cnt; i++)
			if (ratio_val[i] == r) return;
		if (ratio_cnt + need > MAX_RATIO_ENTRIES_DEF) return;
		ratio_val[ratio_cnt] = r;
		ratio_rt[ratio_cnt] = 32'(int_root(longint'(r) << 12));
		ratio_cnt++;
		if (flip_on) begin
			rec = ((64'd1 << 24) + r / 2) / r;
			if (rec > 65535) rec = 65535;
			ratio_val[ratio_cnt] = 32'(rec);
			ratio_rt[ratio_cnt] = 32'(int_root(rec << 12));
			ratio_cnt++;
		end
	endfunction

	// applies one beat to the table state, returns the boxes it yields
	function automatic void predict_boxes(item_t it, ref box_t res[$]);
		longint cx, cy, s, m, g, rt, w, h;
		res.delete();
		case (it.op)
			OP_CLEAR: reset_tables();
			OP_LOAD_SIZE: if (size_cnt < MAX_SIZE_ENTRIES_DEF) begin
				size_lo[size_cnt] = it.min_size;
				size_hi[size_cnt] = it.max_size;
				size_cnt++;
			end
			OP_LOAD_RATIO: add_ratio(it.aspect_ratio);
			OP_GENERATE: begin
				cx = longint'(ctr_off + (int'(it.cell_col) << 8)) * pitch_x;
				cy = longint'(ctr_off + (int'(it.cell_row) << 8)) * pitch_y;
				for (int k = 0; k < size_cnt; k++) begin
					s = size_lo[k];
					m = s << 8;
					res.push_back(make_box(cx, cy, m, m));
					if (mean_on) begin
						g = int_root((s * size_hi[k]) << 16);
						res.push_back(make_box(cx, cy, g, g));
					end
					for (int p = 0; p < ratio_cnt; p++) begin
						rt = ratio_rt[p];
						if (ratio_val[p] == RATIO_ONE || rt == 0) continue;
						w = (s * rt + 8) >> 4;
						h = ((s << 20) + rt / 2) / rt;
						res.push_back(make_box(cx, cy, w, h));
					end
				end
				if (res.size() > 0) res[res.size() - 1].last = 1'b1;
			end
		endcase
	endfunction

	function automatic item_t mk(op_t o, int a, int b, int r, int row, int col);
		item_t it;
		it.op = o;
		it.min_size = 16'(a);
		it.max_size = 16'(b);
		it.aspect_ratio = 16'(r);
		it.cell_row = 10'(row);
		it.cell_col = 10'(col);
		return it;
	endfunction

	task automatic send_beat(item_t it, bit typed, box_t bx);
		box_t res[$];
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= it.op;
		min_size <= it.min_size;
		max_size <= it.max_size;
		aspect_ratio <= it.aspect_ratio;
		cell_row <= it.cell_row;
		cell_col <= it.cell_col;
		do @(posedge clk); while (!in_ready);
		predict_boxes(it, res);
		if (typed) begin
			res.delete();
			res.push_back(bx);
		end
		foreach (res[i]) pending_boxes.push_back(res[i]);
		items_sent++;
	endtask

	task automatic send_item(item_t it);
		box_t none;
		send_beat(it, 1'b0, none);
	endtask

	// sender pause until all boxes are out and the sequencer has gone quiet
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_boxes.size() > 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic cfg_write(cfg_idx_t idx, int unsigned v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 16'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_IMAGE_WIDTH:    img_w = v & 16'h1fff;
			CFG_IMAGE_HEIGHT:   img_h = v & 16'h1fff;
			CFG_STEP_X:         pitch_x = v & 16'hffff;
			CFG_STEP_Y:         pitch_y = v & 16'hffff;
			CFG_CENTER_OFFSET:  ctr_off = v & 8'hff;
			CFG_CLIP_ENABLE:    clip_on = v[0];
			CFG_FLIP_ENABLE:    flip_on = v[0];
			CFG_MAX_BOX_ENABLE: mean_on = v[0];
		endcase
		cfg_writes++;
	endtask

	// a well-formed set-up followed by a few cells, or one random beat of noise
	task automatic random_burst();
		item_t it;
		if ($urandom_range(99) < 75) begin
			send_item(mk(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom));
			repeat ($urandom_range(1, 2))
				send_item(mk(OP_LOAD_SIZE, $urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom, $urandom, $urandom));
			repeat ($urandom_range(0, 2))
				send_item(mk(OP_LOAD_RATIO, $urandom, $urandom, $urandom_range(1024, 16384),
					$urandom, $urandom));
			repeat ($urandom_range(1, 3))
				send_item(mk(OP_GENERATE, $urandom, $urandom, $urandom,
					$urandom_range(0, 1023), $urandom_range(0, 1023)));
		end else begin
			it = mk(op_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom_range(0, 65535),
				$urandom, $urandom);
			send_item(it);
		end
	endtask

	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold > 0) begin
				out_ready <= 1'b0;
				rx_hold--;
			end else
				out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		box_t e;
		if (arst_n && out_valid && out_ready) begin
			boxes_seen++;
			if (pending_boxes.size() == 0) begin
				$error("box beat with nothing expected");
				errors++;
			end else begin
				e = pending_boxes.pop_front();
				if (x_min !== e.x_min) begin
					$error("x_min exp %0d got %0d", e.x_min, x_min); errors++;
				end
				if (y_min !== e.y_min) begin
					$error("y_min exp %0d got %0d", e.y_min, y_min); errors++;
				end
				if (x_max !== e.x_max) begin
					$error("x_max exp %0d got %0d", e.x_max, x_max); errors++;
				end
				if (y_max !== e.y_max) begin
					$error("y_max exp %0d got %0d", e.y_max, y_max); errors++;
				end
				if (last_box !== e.last) begin
					$error("last_box exp %0d got %0d", e.last, last_box); errors++;
				end
			end
		end
	end

	initial begin
		row_t rw;
		box_t ctr;
		int quota;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		op = '0;
		min_size = '0;
		max_size = '0;
		aspect_ratio = '0;
		cell_row = '0;
		cell_col = '0;
		errors = 0;
		items_sent = 0;
		boxes_seen = 0;
		cfg_writes = 0;
		rx_hold = 0;
		tx_idle_pct = 13;
		rx_idle_pct = 46;
		img_w = 300; img_h = 300; pitch_x = 128; pitch_y = 128; ctr_off = 128;
		clip_on = 0; flip_on = 1; mean_on = 0;
		foreach (size_lo[i]) begin
			size_lo[i] = 0;
			size_hi[i] = 0;
		end
		reset_tables();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero-size box at the first cell centre under reset settings: all edges at 4/300
		ctr = '{x_min: 874, y_min: 874, x_max: 874, y_max: 874, last: 1'b1};
		dir_rows.push_back('{mk(OP_GENERATE, 0, 0, 0, 0, 0), 0, ctr});
		dir_rows.push_back('{mk(OP_LOAD_SIZE, 0, 0, 0, 0, 0), 0, ctr});
		dir_rows.push_back('{mk(OP_GENERATE, 0, 0, 0, 0, 0), 1, ctr});
		dir_rows.push_back('{mk(OP_LOAD_RATIO, 0, 0, 0, 0, 0), 0, ctr});
		dir_rows.push_back('{mk(OP_LOAD_RATIO, 0, 0, RATIO_ONE, 0, 0), 0, ctr});
		dir_rows.push_back('{mk(OP_LOAD_RATIO, 0, 0, 8192, 0, 0), 0, ctr});
		dir_rows.push_back('{mk(OP_LOAD_RATIO, 0, 0, 2048, 0, 0), 0, ctr});
		dir_rows.push_back('{mk(OP_LOAD_RATIO, 0, 0, 65535, 0, 0), 0, ctr});
		dir_rows.push_back('{mk(OP_LOAD_RATIO, 0, 0, 1, 0, 0), 0, ctr});
		dir_rows.push_back('{mk(OP_LOAD_RATIO, 0, 0, 12288, 0, 0), 0, ctr});
		dir_rows.push_back('{mk(OP_LOAD_SIZE, 65535, 65535, 0, 0, 0), 0, ctr});
		dir_rows.push_back('{mk(OP_LOAD_SIZE, 1, 65535, 0, 0, 0), 0, ctr});
		dir_rows.push_back('{mk(OP_LOAD_SIZE, 480, 960, 0, 0, 0), 0, ctr});
		dir_rows.push_back('{mk(OP_LOAD_SIZE, 100, 200, 0, 0, 0), 0, ctr});
		dir_rows.push_back('{mk(OP_GENERATE, 0, 0, 0, 1023, 1023), 0, ctr});
		dir_rows.push_back('{mk(OP_GENERATE, 0, 0, 0, 0, 1023), 0, ctr});
		dir_rows.push_back('{mk(OP_CLEAR, 0, 0, 0, 0, 0), 0, ctr});
		dir_rows.push_back('{mk(OP_LOAD_SIZE, 800, 1600, 0, 0, 0), 0, ctr});
		dir_rows.push_back('{mk(OP_GENERATE, 0, 0, 0, 5, 7), 0, ctr});
		foreach (dir_rows[i]) begin
			rw = dir_rows[i];
			send_beat(rw.it, rw.typed, rw.bx);
		end
		drain();

		// fill the queue while the output is held off
		send_item(mk(OP_LOAD_SIZE, 320, 640, 0, 0, 0));
		rx_hold = 3000;
		repeat (4) send_item(mk(OP_GENERATE, 0, 0, 0, $urandom_range(0, 1023),
			$urandom_range(0, 1023)));
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph / 2)
				0: begin tx_idle_pct = 13; rx_idle_pct = 46; end
				1: begin tx_idle_pct = 46; rx_idle_pct = 13; end
				default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
			endcase
			case (ph)
				0: begin
					cfg_write(CFG_IMAGE_WIDTH, 1); cfg_write(CFG_IMAGE_HEIGHT, 4096);
					cfg_write(CFG_STEP_X, 1); cfg_write(CFG_STEP_Y, 65535);
					cfg_write(CFG_CENTER_OFFSET, 0); cfg_write(CFG_CLIP_ENABLE, 1);
					cfg_write(CFG_FLIP_ENABLE, 0); cfg_write(CFG_MAX_BOX_ENABLE, 1);
				end
				1: begin
					cfg_write(CFG_IMAGE_WIDTH, 4096); cfg_write(CFG_IMAGE_HEIGHT, 1);
					cfg_write(CFG_STEP_X, 65535); cfg_write(CFG_STEP_Y, 1);
					cfg_write(CFG_CENTER_OFFSET, 255); cfg_write(CFG_CLIP_ENABLE, 0);
					cfg_write(CFG_FLIP_ENABLE, 1); cfg_write(CFG_MAX_BOX_ENABLE, 0);
				end
				2: begin
					// zero size reads as one, top bits of the field too
					cfg_write(CFG_IMAGE_WIDTH, 0); cfg_write(CFG_IMAGE_HEIGHT, 8191);
					cfg_write(CFG_MAX_BOX_ENABLE, 1);
				end
				default: begin
					cfg_write(CFG_IMAGE_WIDTH, $urandom_range(1, 8191));
					cfg_write(CFG_IMAGE_HEIGHT, $urandom_range(1, 8191));
					cfg_write(CFG_STEP_X, $urandom_range(1, 65535));
					cfg_write(CFG_STEP_Y, $urandom_range(1, 65535));
					cfg_write(CFG_CENTER_OFFSET, $urandom_range(0, 255));
					cfg_write(CFG_CLIP_ENABLE, $urandom_range(0, 1));
					cfg_write(CFG_FLIP_ENABLE, $urandom_range(0, 1));
					cfg_write(CFG_MAX_BOX_ENABLE, $urandom_range(0, 1));
				end
			endcase
			quota = items_sent + 17;
			while (items_sent < quota) random_burst();
			drain();
		end

		$display("ran %0d beats in, checked %0d boxes out, %0d register writes",
			items_sent, boxes_seen, cfg_writes);
		$display("covered table loads, overflow, duplicates, clip and saturation, idling and stalls");
		if (errors == 0 && pending_boxes.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire

/* sim.f */
rtl/core/abg_pkg.sv
rtl/core/abg_front.sv
rtl/core/abg_div.sv
rtl/core/abg_sqrt.sv
rtl/core/abg_back.sv
rtl/core/anchor_box_generator.sv
tb/sv/tb_top.sv
